>>> design/request_dedup_lru_table_defines.svh
// assertion macros for the request dedup lru table
// used by the top-level rtl file that carries concurrent checks; no other dependencies
`ifndef REQUEST_DEDUP_LRU_TABLE_DEFINES_SVH
`define REQUEST_DEDUP_LRU_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
// check sampled on clock, disabled while reset is high
`define RDLT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check sampled on clock, also active during reset
`define RDLT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define RDLT_ASSERT(lbl, prop, msg)
`define RDLT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> design/rdlt_pkg.sv
// shared types and sizes for the request dedup lru table
// no dependencies
package rdlt_pkg;

   localparam int ENTRIES    = 64;
   localparam int KEY_BITS   = 64;
   localparam int VALUE_BITS = 64;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int RANK_W     = IDX_W;

   localparam logic FUNC_CHECK  = 1'b0;
   localparam logic FUNC_RECORD = 1'b1;

   // result of a key search pass
   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  hit_slot;
      logic [RANK_W-1:0] hit_rank;
      logic [IDX_W-1:0]  victim_slot;
   } match_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

endpackage

>>> design/rdlt_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module rdlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rdlt_match.sv
// search accumulator: compares streamed keys against the request key and ranks against zero
// depends on rdlt_pkg
module rdlt_match
   import rdlt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                sample,
   input  logic [IDX_W-1:0]    slot,
   input  logic [KEY_BITS-1:0] key_rd,
   input  logic [KEY_BITS-1:0] key_req,
   input  logic [RANK_W-1:0]   rank_rd,
   output match_type           match
);

   match_type match_ff, match_in;

   // keep the first matching slot and the slot that holds rank zero
   always_comb begin
      match_in = match_ff;
      if (clear) begin
         match_in.hit = 1'b0;
      end else if (sample) begin
         if (!match_ff.hit && key_rd == key_req) begin
            match_in.hit      = 1'b1;
            match_in.hit_slot = slot;
            match_in.hit_rank = rank_rd;
         end
         if (rank_rd == '0) begin
            match_in.victim_slot = slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match = match_ff;

endmodule

>>> design/request_dedup_lru_table.sv
// top level of the request dedup lru table: sequencer and state memories
// depends on rdlt_pkg, rdlt_ram, rdlt_match and the defines header
//
// channel    direction  ports                         handshake
// request    in         req_func .. req_result_value  start high, busy low
// response   out        rsp_status .. rsp_entry_count rsp_strobe, one cycle
//
// a request scans all valid entries on the key and rank memory read port;
// a hit or a full-table record runs a second pass over the rank memory to
// age ranks. reset clears the occupied count but not the memories, which
// need no clearing pass. busy stays high until the response cycle ends; the
// response cannot be stalled.
`include "request_dedup_lru_table_defines.svh"
module request_dedup_lru_table
   import rdlt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [63:0] req_request_key,
   input  logic        req_has_result,
   input  logic [63:0] req_result_value,
   output logic        rsp_strobe,
   output logic        rsp_status,
   output logic [63:0] rsp_cached_value,
   output logic        rsp_evicted,
   output logic [6:0]  rsp_entry_count
);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic issue_ff, issue_in;
   logic rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   logic func_ff, has_result_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [IDX_W-1:0] tgt_slot_ff, tgt_slot_in;
   logic [RANK_W-1:0] tgt_rank_ff, tgt_rank_in;
   logic status_ff, status_in, evicted_ff, evicted_in, cached_sel_ff, cached_sel_in;

   logic accept;
   logic last_rd;
   logic [IDX_W-1:0] last_idx;

   logic key_we, val_we, rank_we, val_re;
   logic [IDX_W-1:0] key_wa, val_wa, rank_wa, val_ra;
   logic [VALUE_BITS-1:0] val_wd, val_rd;
   logic [RANK_W-1:0] rank_wd, rank_rd;
   logic [KEY_BITS-1:0] key_rd;
   match_type match;

   assign accept   = start && (state_ff == ST_IDLE);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign last_rd  = rd_vld_ff && (rd_idx_ff == last_idx);

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff       <= req_func;
         key_ff        <= req_request_key[KEY_BITS-1:0];
         has_result_ff <= req_has_result;
         value_ff      <= req_result_value[VALUE_BITS-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      issue_in      = issue_ff;
      tgt_slot_in   = tgt_slot_ff;
      tgt_rank_in   = tgt_rank_ff;
      status_in     = status_ff;
      evicted_in    = evicted_ff;
      cached_sel_in = cached_sel_ff;
      key_we  = 1'b0;
      key_wa  = tgt_slot_ff;
      val_we  = 1'b0;
      val_wa  = tgt_slot_ff;
      val_wd  = value_ff;
      val_re  = 1'b0;
      val_ra  = match.hit_slot;
      rank_we = 1'b0;
      rank_wa = rd_idx_ff;
      rank_wd = rank_rd;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in     = 1'b0;
               evicted_in    = 1'b0;
               cached_sel_in = 1'b0;
               idx_in        = '0;
               issue_in      = (count_ff != '0);
               state_in      = (count_ff != '0) ? ST_SEARCH : ST_DECIDE;
            end
         end
         ST_SEARCH: begin
            if (issue_ff) begin
               idx_in   = idx_ff + IDX_W'(1);
               issue_in = (idx_ff != last_idx);
            end
            if (last_rd) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            idx_in   = '0;
            issue_in = 1'b1;
            if (match.hit) begin
               // hit: age ranks around this slot
               status_in   = 1'b1;
               tgt_slot_in = match.hit_slot;
               tgt_rank_in = match.hit_rank;
               if (func_ff == FUNC_CHECK) begin
                  val_re        = 1'b1;
                  cached_sel_in = 1'b1;
               end else if (has_result_ff) begin
                  val_we = 1'b1;
                  val_wa = match.hit_slot;
               end
               state_in = ST_UPDATE;
            end else if (func_ff == FUNC_CHECK) begin
               issue_in = 1'b0;
               state_in = ST_RESP;
            end else if (count_ff < CNT_W'(ENTRIES)) begin
               // append in the next free slot as most recent
               issue_in = 1'b0;
               key_we   = 1'b1;
               key_wa   = IDX_W'(count_ff);
               val_we   = 1'b1;
               val_wa   = IDX_W'(count_ff);
               val_wd   = has_result_ff ? value_ff : '0;
               rank_we  = 1'b1;
               rank_wa  = IDX_W'(count_ff);
               rank_wd  = RANK_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
               state_in = ST_RESP;
            end else begin
               // full: reuse the rank zero slot and age everyone else
               evicted_in  = 1'b1;
               tgt_slot_in = match.victim_slot;
               tgt_rank_in = '0;
               key_we      = 1'b1;
               key_wa      = match.victim_slot;
               val_we      = 1'b1;
               val_wa      = match.victim_slot;
               val_wd      = has_result_ff ? value_ff : '0;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (issue_ff) begin
               idx_in   = idx_ff + IDX_W'(1);
               issue_in = (idx_ff != last_idx);
            end
            // write back lags the read by one slot, so no address overlaps
            if (rd_vld_ff) begin
               rank_we = 1'b1;
               if (rd_idx_ff == tgt_slot_ff) begin
                  rank_wd = RANK_W'(count_ff - CNT_W'(1));
               end else if (rank_rd > tgt_rank_ff) begin
                  rank_wd = rank_rd - RANK_W'(1);
               end
            end
            if (last_rd) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         issue_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         issue_ff  <= issue_in;
         rd_vld_ff <= issue_ff && (state_ff == ST_SEARCH || state_ff == ST_UPDATE);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rd_idx_ff     <= idx_ff;
      tgt_slot_ff   <= tgt_slot_in;
      tgt_rank_ff   <= tgt_rank_in;
      status_ff     <= status_in;
      evicted_ff    <= evicted_in;
      cached_sel_ff <= cached_sel_in;
   end

   // state memories
   rdlt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (key_ff),
      .rd_en   (issue_ff && state_ff == ST_SEARCH),
      .rd_addr (idx_ff),
      .rd_data (key_rd)
   );

   rdlt_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_wd),
      .rd_en   (val_re),
      .rd_addr (val_ra),
      .rd_data (val_rd)
   );

   rdlt_ram #(.WIDTH(RANK_W), .DEPTH(ENTRIES)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_wa),
      .wr_data (rank_wd),
      .rd_en   (issue_ff),
      .rd_addr (idx_ff),
      .rd_data (rank_rd)
   );

   // key search
   rdlt_match u_match (
      .clock   (clock),
      .reset   (reset),
      .clear   (accept),
      .sample  (rd_vld_ff && state_ff == ST_SEARCH),
      .slot    (rd_idx_ff),
      .key_rd  (key_rd),
      .key_req (key_ff),
      .rank_rd (rank_rd),
      .match   (match)
   );

   // response
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = (state_ff == ST_RESP);
   assign rsp_status       = status_ff;
   assign rsp_evicted      = evicted_ff;
   assign rsp_cached_value = cached_sel_ff ? 64'(val_rd) : 64'd0;
   assign rsp_entry_count  = 7'(count_ff);

   `RDLT_ASSERT_ALWAYS(a_count_range, reset || count_ff <= CNT_W'(ENTRIES), "occupied count over depth")
   `RDLT_ASSERT(a_strobe_single, rsp_strobe |=> !rsp_strobe, "response longer than one cycle")
   `RDLT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "request accepted without busy")
   `RDLT_ASSERT(a_evict_full, (rsp_strobe && rsp_evicted) |-> count_ff == CNT_W'(ENTRIES),
      "eviction on a table that is not full")
   `RDLT_ASSERT(a_check_count, (state_ff == ST_DECIDE && func_ff == FUNC_CHECK) |=>
      $stable(count_ff), "check changed occupied count")

endmodule

>>> verif/tb_top.sv
// testbench for the request dedup lru table: directed table, a fill past full, then random requests
// depends on rdlt_pkg and request_dedup_lru_table; checks responses against a local lru predictor
module tb_top
   import rdlt_pkg::*;
();

   localparam int CYCLE_LIMIT = 2000000;
   localparam int NUM_RANDOM  = 1800;

   typedef struct packed {
      logic        status;
      logic [63:0] cached_value;
      logic        evicted;
      logic [6:0]  entry_count;
   } lookup_rsp_type;

   typedef struct {
      logic           func;
      logic [63:0]    key;
      logic           has_result;
      logic [63:0]    value;
      logic           typed;     // expected response below is given by hand
      lookup_rsp_type rsp;
   } table_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_func;
   logic [63:0] req_request_key;
   logic        req_has_result;
   logic [63:0] req_result_value;
   logic        rsp_strobe;
   logic        rsp_status;
   logic [63:0] rsp_cached_value;
   logic        rsp_evicted;
   logic [6:0]  rsp_entry_count;

   // predictor state
   logic [63:0] lru_keys[ENTRIES];
   logic [63:0] lru_values[ENTRIES];
   int          lru_rank[ENTRIES];
   int          lru_count;

   lookup_rsp_type pending_rsp[$];
   lookup_rsp_type typed_rsp[$];
   logic           typed_valid[$];
   logic [63:0]    key_pool[$];
   table_row_type  directed[$];
   int             fail_count = 0;
   int             cycle_count = 0;

   request_dedup_lru_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_request_key(req_request_key),
      .req_has_result(req_has_result), .req_result_value(req_result_value),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_cached_value(rsp_cached_value), .rsp_evicted(rsp_evicted),
      .rsp_entry_count(rsp_entry_count)
   );

   // clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // promote one slot to most recent
   function automatic void lru_touch(int slot);
      int r;
      r = lru_rank[slot];
      for (int i = 0; i < lru_count; i++)
         if (lru_rank[i] > r) lru_rank[i]--;
      lru_rank[slot] = lru_count - 1;
   endfunction

   // apply one request to the predictor, return the expected response
   function automatic lookup_rsp_type lru_apply(logic func, logic [63:0] key,
                                                logic has_result, logic [63:0] value);
      lookup_rsp_type r;
      int slot;
      int victim;
      r = '{1'b0, 64'd0, 1'b0, 7'd0};
      slot = -1;
      victim = 0;
      for (int i = 0; i < lru_count; i++)
         if (slot < 0 && lru_keys[i] == key) slot = i;
      if (func == FUNC_CHECK) begin
         if (slot >= 0) begin
            lru_touch(slot);
            r.status = 1'b1;
            r.cached_value = lru_values[slot];
         end
      end else begin
         if (slot >= 0) begin
            r.status = 1'b1;
            lru_touch(slot);
         end else begin
            if (lru_count >= ENTRIES) begin
               for (int i = lru_count - 1; i >= 0; i--)
                  if (lru_rank[i] == 0) victim = i;
               for (int i = victim; i + 1 < lru_count; i++) begin
                  lru_keys[i] = lru_keys[i+1];
                  lru_values[i] = lru_values[i+1];
                  lru_rank[i] = lru_rank[i+1];
               end
               lru_count--;
               for (int i = 0; i < lru_count; i++) lru_rank[i]--;
               r.evicted = 1'b1;
            end
            slot = lru_count;
            lru_count++;
            lru_keys[slot] = key;
            lru_values[slot] = 64'd0;
            lru_rank[slot] = lru_count - 1;
         end
         if (has_result) lru_values[slot] = value;
      end
      r.entry_count = 7'(lru_count);
      return r;
   endfunction

   // random key, mostly from a pool a bit larger than the table
   function automatic logic [63:0] pick_key();
      logic [63:0] k;
      if (key_pool.size() > 0 && $urandom_range(0, 9) < 8)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      k = {$urandom, $urandom};
      if (key_pool.size() < 90) key_pool.push_back(k);
      else key_pool[$urandom_range(0, 89)] = k;
      return k;
   endfunction

   // send one request and queue its expectation
   task automatic send_request(logic func, logic [63:0] key, logic has_result,
                               logic [63:0] value, logic typed, lookup_rsp_type rsp);
      start <= 1'b1;
      req_func <= func;
      req_request_key <= key;
      req_has_result <= has_result;
      req_result_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(lru_apply(func, key, has_result, value));
      typed_rsp.push_back(rsp);
      typed_valid.push_back(typed);
   endtask

   function automatic table_row_type mk_row(logic func, logic [63:0] key, logic has_result,
                                            logic [63:0] value, logic typed,
                                            logic st, logic [63:0] cv, logic ev,
                                            logic [6:0] cnt);
      table_row_type t;
      t.func = func; t.key = key; t.has_result = has_result; t.value = value;
      t.typed = typed;
      t.rsp = '{st, cv, ev, cnt};
      return t;
   endfunction

   // response checker
   always @(posedge clock) begin
      lookup_rsp_type e;
      lookup_rsp_type t;
      logic tv;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response status %0b count %0d",
                     $time, rsp_status, rsp_entry_count);
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            t = typed_rsp.pop_front();
            tv = typed_valid.pop_front();
            if (tv && t != e) begin
               $display("%0t: typed row expected %h predictor %h", $time, t, e);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0b actual %0b", $time, e.status, rsp_status);
               fail_count++;
            end
            if (rsp_cached_value !== e.cached_value) begin
               $display("%0t: cached_value expected %h actual %h",
                        $time, e.cached_value, rsp_cached_value);
               fail_count++;
            end
            if (rsp_evicted !== e.evicted) begin
               $display("%0t: evicted expected %0b actual %0b", $time, e.evicted, rsp_evicted);
               fail_count++;
            end
            if (rsp_entry_count !== e.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, e.entry_count, rsp_entry_count);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("request_dedup_lru_table verification failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      lookup_rsp_type none;
      logic [63:0] k;
      int burst;
      int wait_cycles;
      lru_count = 0;
      none = '{1'b0, 64'd0, 1'b0, 7'd0};
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_CHECK;
      req_request_key = '0;
      req_has_result = 1'b0;
      req_result_value = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed rows: check miss on empty, extremes, record hit with and without result
      directed.push_back(mk_row(FUNC_CHECK, 64'd0, 1'b1, '1, 1'b1,
                                1'b0, 64'd0, 1'b0, 7'd0));
      directed.push_back(mk_row(FUNC_RECORD, 64'd0, 1'b0, '1, 1'b1,
                                1'b0, 64'd0, 1'b0, 7'd1));
      directed.push_back(mk_row(FUNC_CHECK, 64'd0, 1'b0, 64'd0, 1'b1,
                                1'b1, 64'd0, 1'b0, 7'd1));
      directed.push_back(mk_row(FUNC_RECORD, '1, 1'b1, '1, 1'b1,
                                1'b0, 64'd0, 1'b0, 7'd2));
      directed.push_back(mk_row(FUNC_CHECK, '1, 1'b0, 64'd0, 1'b1,
                                1'b1, '1, 1'b0, 7'd2));
      directed.push_back(mk_row(FUNC_RECORD, '1, 1'b0, 64'h5a5a, 1'b1,
                                1'b1, 64'd0, 1'b0, 7'd2));
      directed.push_back(mk_row(FUNC_CHECK, '1, 1'b0, 64'd0, 1'b1,
                                1'b1, '1, 1'b0, 7'd2));
      directed.push_back(mk_row(FUNC_RECORD, 64'd0, 1'b1, 64'h8000_0000_0000_0001,
                                1'b1, 1'b1, 64'd0, 1'b0, 7'd2));
      directed.push_back(mk_row(FUNC_CHECK, 64'd0, 1'b1, '1, 1'b1, 1'b1,
                                64'h8000_0000_0000_0001, 1'b0, 7'd2));
      directed.push_back(mk_row(FUNC_CHECK, 64'h8000_0000_0000_0000, 1'b0, 64'd0,
                                1'b1, 1'b0, 64'd0, 1'b0, 7'd2));
      foreach (directed[i])
         send_request(directed[i].func, directed[i].key, directed[i].has_result,
                      directed[i].value, directed[i].typed, directed[i].rsp);

      // fill the table past full to force evictions, then touch and refill
      for (int i = 0; i < ENTRIES + 6; i++)
         send_request(FUNC_RECORD, 64'h100 + i, i[0], {32'hcafe, i}, 1'b0, none);
      send_request(FUNC_CHECK, 64'h100 + 10, 1'b0, 64'd0, 1'b0, none);
      send_request(FUNC_RECORD, 64'h1000, 1'b1, 64'h1, 1'b0, none);
      send_request(FUNC_CHECK, 64'h100 + 7, 1'b0, 64'd0, 1'b0, none);

      // random requests in bursts with gaps
      for (int n = 0; n < NUM_RANDOM; ) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++) begin
            k = pick_key();
            send_request(1'($urandom_range(0, 1)), k, 1'($urandom_range(0, 1)),
                         {$urandom, $urandom}, 1'b0, none);
         end
         wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (wait_cycles > 0) begin
            start <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
      end
      start <= 1'b0;

      // drain
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (2 * ENTRIES + 10) @(posedge clock);
      if (fail_count == 0)
         $display("request_dedup_lru_table verification clean");
      else
         $display("request_dedup_lru_table verification failed");
      $finish;
   end

endmodule
